### src/lcdsp_pkg.sv
`timescale 1ns / 1ps

package lcdsp_pkg;

   localparam int WEIGHT_W  = 16;
   localparam int FRAC_BITS = 12;
   localparam int BYTE_W    = 8;
   localparam int IDX_W     = 2;
   localparam int LEVEL_IN_W = 7;
   localparam int TAIL_BYTES = 4;
   localparam int TAPS       = 5;

   localparam logic [IDX_W-1:0] REG_PRIMARY   = 2'd0;
   localparam logic [IDX_W-1:0] REG_SECONDARY = 2'd1;
   localparam logic [IDX_W-1:0] REG_TERTIARY  = 2'd2;

   localparam logic [WEIGHT_W-1:0] PRIMARY_RESET   = 16'd14283;
   localparam logic [WEIGHT_W-1:0] SECONDARY_RESET = 16'd1428;
   localparam logic [WEIGHT_W-1:0] TERTIARY_RESET  = 16'd357;

   localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

   typedef struct packed {
      logic [WEIGHT_W-1:0] primary;
      logic [WEIGHT_W-1:0] secondary;
      logic [WEIGHT_W-1:0] tertiary;
   } weights_type;

endpackage

### src/lcd_subpixel_filter.sv
`timescale 1ns / 1ps

// Five-tap subpixel filter: each accepted gray level (clamped to LEVELS-1) is spread over
// five subpixel bytes with weights tertiary, secondary, primary, secondary, tertiary
// (Q4.12, set through the csr port while idle). An ordinary pixel gives one byte, so a
// continuous stream runs at one transaction per clock while rsp_ready is high. A pixel
// flagged row_end gives its byte, four tail bytes and zero padding up to a row length
// that is a multiple of ROW_ALIGN plus four: 5 to 4 + ROW_ALIGN result bytes, one per
// cycle from the single work register while rsp_ready is high, during which req_ready is
// held low. run_last marks the last byte of each input transaction and row_last the last
// byte of a row. An input transaction passes the work register, then the result register,
// before its first result transaction appears.

module lcd_subpixel_filter
   import lcdsp_pkg::*;
#(
   parameter int LEVELS    = 65,
   parameter int ROW_ALIGN = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [LEVEL_IN_W-1:0] req_level,
   input  logic                  req_row_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_subpixel_value,
   output logic                  rsp_run_last,
   output logic                  rsp_row_last,
   input  logic                  csr_write_enable,
   input  logic [IDX_W-1:0]      csr_index,
   input  logic [WEIGHT_W-1:0]   csr_wdata
);

   localparam int LEVEL_W = $clog2(LEVELS);
   localparam int PHASE_W = (ROW_ALIGN > 1) ? $clog2(ROW_ALIGN) : 1;
   localparam int CNT_W   = $clog2(TAIL_BYTES + ROW_ALIGN);
   localparam int HIST    = TAPS - 1;

   weights_type weights;

   logic [HIST-1:0][LEVEL_W-1:0] tap_window_ff, tap_window_in;
   logic [PHASE_W-1:0]           column_phase_ff, column_phase_in;

   logic                         work_valid_ff, work_valid_in;
   logic [TAPS-1:0][LEVEL_W-1:0] work_taps_ff, work_taps_in;
   logic [CNT_W-1:0]             work_cnt_ff, work_cnt_in;
   logic                         work_row_end_ff, work_row_end_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]            rsp_value_ff, rsp_value_in;
   logic                         rsp_run_last_ff, rsp_run_last_in;
   logic                         rsp_row_last_ff, rsp_row_last_in;

   logic [LEVEL_W-1:0] level_clamped;
   logic               accept;
   logic               advance;
   logic               phase_wrap;
   logic [CNT_W-1:0]   pad;
   logic [BYTE_W-1:0]  filtered;

   lcdsp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .weights          (weights)
   );

   lcdsp_datapath #(
      .LEVEL_W (LEVEL_W)
   ) u_datapath (
      .taps           (work_taps_ff),
      .weights        (weights),
      .subpixel_value (filtered)
   );

   assign advance   = work_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !work_valid_ff || (advance && (work_cnt_ff == '0));
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (32'(req_level) > LEVELS - 1) begin
         level_clamped = LEVEL_W'(LEVELS - 1);
      end else begin
         level_clamped = LEVEL_W'(req_level);
      end
   end

   // width mod ROW_ALIGN after this pixel is zero when the phase wraps
   assign phase_wrap = (32'(column_phase_ff) == ROW_ALIGN - 1);
   assign pad = phase_wrap ? '0 : CNT_W'(ROW_ALIGN - 1 - 32'(column_phase_ff));

   always_comb begin
      tap_window_in   = tap_window_ff;
      column_phase_in = column_phase_ff;
      if (accept) begin
         if (req_row_end) begin
            tap_window_in   = '0;
            column_phase_in = '0;
         end else begin
            tap_window_in   = {tap_window_ff[HIST-2:0], level_clamped};
            column_phase_in = phase_wrap ? '0 : column_phase_ff + 1'b1;
         end
      end
   end

   always_comb begin
      work_valid_in   = work_valid_ff;
      work_taps_in    = work_taps_ff;
      work_cnt_in     = work_cnt_ff;
      work_row_end_in = work_row_end_ff;
      priority if (advance && (work_cnt_ff != '0)) begin
         // tail and padding: shift zero levels in
         work_taps_in = {work_taps_ff[TAPS-2:0], {LEVEL_W{1'b0}}};
         work_cnt_in  = work_cnt_ff - 1'b1;
      end else if (accept) begin
         work_valid_in   = 1'b1;
         work_taps_in    = {tap_window_ff, level_clamped};
         work_cnt_in     = req_row_end ? CNT_W'(TAIL_BYTES) + pad : '0;
         work_row_end_in = req_row_end;
      end else if (advance) begin
         work_valid_in = 1'b0;
      end else begin
         work_valid_in = work_valid_ff;
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_run_last_in = rsp_run_last_ff;
      rsp_row_last_in = rsp_row_last_ff;
      priority if (advance) begin
         rsp_valid_in    = 1'b1;
         rsp_value_in    = filtered;
         rsp_run_last_in = (work_cnt_ff == '0);
         rsp_row_last_in = work_row_end_ff && (work_cnt_ff == '0);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_window_ff   <= '0;
         column_phase_ff <= '0;
         work_valid_ff   <= 1'b0;
         work_cnt_ff     <= '0;
         work_row_end_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         tap_window_ff   <= tap_window_in;
         column_phase_ff <= column_phase_in;
         work_valid_ff   <= work_valid_in;
         work_cnt_ff     <= work_cnt_in;
         work_row_end_ff <= work_row_end_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_taps_ff    <= work_taps_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_row_last_ff <= rsp_row_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_subpixel_value = rsp_value_ff;
   assign rsp_run_last       = rsp_run_last_ff;
   assign rsp_row_last       = rsp_row_last_ff;

   a_row_end_clears_window: assert property (
      @(posedge clock) disable iff (reset)
      accept && req_row_end |=> (tap_window_ff == '0) && (column_phase_ff == '0)
   ) else $error("tap window not cleared after row end");

   a_tail_needs_work: assert property (
      @(posedge clock) disable iff (reset)
      (work_cnt_ff != '0) |-> work_valid_ff && work_row_end_ff
   ) else $error("tail count without a row-end transaction");

   a_stall_only_when_busy: assert property (
      @(posedge clock) disable iff (reset)
      !req_ready |-> work_valid_ff
   ) else $error("input stalled with empty work register");

   a_row_last_ends_run: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_last |-> rsp_run_last
   ) else $error("row_last without run_last");

   a_tail_no_accept: assert property (
      @(posedge clock) disable iff (reset)
      work_valid_ff && (work_cnt_ff != '0) |-> !req_ready
   ) else $error("input accepted during row tail");

endmodule

### src/lcdsp_csr.sv
`timescale 1ns / 1ps

module lcdsp_csr
   import lcdsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [WEIGHT_W-1:0] csr_wdata,
   output weights_type         weights
);

   weights_type weights_ff, weights_in;

   always_comb begin
      weights_in = weights_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_PRIMARY:   weights_in.primary   = csr_wdata;
            REG_SECONDARY: weights_in.secondary = csr_wdata;
            REG_TERTIARY:  weights_in.tertiary  = csr_wdata;
            default:       weights_in = weights_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff.primary   <= PRIMARY_RESET;
         weights_ff.secondary <= SECONDARY_RESET;
         weights_ff.tertiary  <= TERTIARY_RESET;
      end else begin
         weights_ff <= weights_in;
      end
   end

   assign weights = weights_ff;

endmodule

### src/lcdsp_datapath.sv
`timescale 1ns / 1ps

module lcdsp_datapath
   import lcdsp_pkg::*;
#(
   parameter int LEVEL_W = 7
)
(
   input  logic [TAPS-1:0][LEVEL_W-1:0] taps,
   input  weights_type                  weights,
   output logic [BYTE_W-1:0]            subpixel_value
);

   localparam int PROD_W = WEIGHT_W + LEVEL_W;
   localparam int TERM_W = PROD_W - FRAC_BITS;
   localparam int SUM_W  = TERM_W + 3;

   logic [TAPS-1:0][WEIGHT_W-1:0] tap_weight;
   logic [TAPS-1:0][PROD_W-1:0]   product;
   logic [SUM_W-1:0]              sum;

   // taps[0] newest, taps[4] oldest; symmetric kernel
   assign tap_weight[0] = weights.tertiary;
   assign tap_weight[1] = weights.secondary;
   assign tap_weight[2] = weights.primary;
   assign tap_weight[3] = weights.secondary;
   assign tap_weight[4] = weights.tertiary;

   always_comb begin
      sum = '0;
      for (int i = 0; i < TAPS; i++) begin
         product[i] = PROD_W'(tap_weight[i]) * PROD_W'(taps[i]);
         sum = sum + SUM_W'(product[i][PROD_W-1:FRAC_BITS]);
      end
      if (sum > SUM_W'(BYTE_MAX)) begin
         subpixel_value = BYTE_MAX;
      end else begin
         subpixel_value = sum[BYTE_W-1:0];
      end
   end

endmodule
